### hdl/assert_macros.svh
// assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### hdl/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// shared types and constants of the epoch to calendar converter
// ----------------------------------------------------------------------------
`default_nettype none
package e2c_pkg;
  localparam int unsigned EpochBits = 32;
  localparam int unsigned DayBits   = 16;
  localparam int unsigned SodBits   = 17;

  // time-of-day stage payload
  typedef struct packed {
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
    logic [2:0] weekday;
  } tod_t;

  // date breakdown
  typedef struct packed {
    logic [11:0] year;
    logic [8:0]  day_of_year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
  } date_t;

  // only 2100 is a non-leap century within 1970..2106
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != 12'd2100);
  endfunction
endpackage
`default_nettype wire

### hdl/e2c_split.sv
// ----------------------------------------------------------------------------
// e2c_split
// splits seconds into day count and time of day over four stages
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module e2c_split (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           vld_i,
  input  logic [e2c_pkg::EpochBits-1:0] secs_i,
  output logic                           vld_o,
  output logic [e2c_pkg::DayBits-1:0]   days_o,
  output e2c_pkg::tod_t                  tod_o
);
  // stage a: day count by reciprocal multiply (floor(t/86400) = t*k >> 48)
  logic        va_q, vb_q, vc_q, vd_q;
  logic [63:0] day_prod;
  logic [e2c_pkg::DayBits-1:0] da_d, da_q, db_q, dc_q, dd_q;
  logic [e2c_pkg::SodBits-1:0] ta_q;

  assign day_prod = 64'(secs_i) * 64'd3257812231;
  assign da_d     = day_prod[63:48];

  // stage b: seconds of the day from the low bits, weekday quotient (days+4)/7
  logic [32:0] day_base;
  logic [16:0] dplus;
  logic [35:0] wk_prod;
  logic [e2c_pkg::SodBits-1:0] sodb_d, sodb_q;
  logic [12:0] wqb_d, wqb_q;
  logic [16:0] wpb_q;

  assign day_base = 33'(da_q) * 33'd86400;
  assign sodb_d   = ta_q - day_base[e2c_pkg::SodBits-1:0];
  assign dplus    = {1'b0, da_q} + 17'd4;
  assign wk_prod  = 36'(dplus) * 36'd74899;
  assign wqb_d    = wk_prod[31:19];

  // stage c: hour and minute of day in parallel, weekday remainder
  logic [35:0] hr_prod;
  logic [35:0] mt_prod;
  logic [4:0]  hrc_d, hrc_q;
  logic [10:0] mtc_d, mtc_q;
  logic [2:0]  wdc_d, wdc_q;
  logic [e2c_pkg::SodBits-1:0] sodc_q;

  assign hr_prod = 36'(sodb_q) * 36'd37283;
  assign hrc_d   = hr_prod[31:27];
  assign mt_prod = 36'(sodb_q) * 36'd139811;
  assign mtc_d   = mt_prod[33:23];
  assign wdc_d   = 3'(wpb_q - 17'(wqb_q) * 17'd7);

  // stage d: second and minute
  logic [5:0] sec_d;
  logic [5:0] min_d;
  e2c_pkg::tod_t tod_q;

  assign sec_d = 6'(sodc_q - 17'(mtc_q) * 17'd60);
  assign min_d = 6'(mtc_q - 11'(hrc_q) * 11'd60);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else if (en_i) begin
      va_q <= vld_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ta_q   <= secs_i[e2c_pkg::SodBits-1:0];
      da_q   <= da_d;
      db_q   <= da_q;
      sodb_q <= sodb_d;
      wqb_q  <= wqb_d;
      wpb_q  <= dplus;
      dc_q   <= db_q;
      sodc_q <= sodb_q;
      hrc_q  <= hrc_d;
      mtc_q  <= mtc_d;
      wdc_q  <= wdc_d;
      dd_q   <= dc_q;
      tod_q  <= '{second: sec_d, minute: min_d, hour: hrc_q, weekday: wdc_q};
    end
  end

  assign vld_o  = vd_q;
  assign days_o = dd_q;
  assign tod_o  = tod_q;

  `ASSERT_IMPL(a_sod_range, clk_i, rst_ni, vb_q, sodb_q < 17'd86400)
  `ASSERT_IMPL(a_hour_range, clk_i, rst_ni, vd_q, tod_q.hour < 5'd24)
  `ASSERT_IMPL(a_min_range, clk_i, rst_ni, vd_q, tod_q.minute < 6'd60)
  `ASSERT_IMPL(a_sec_range, clk_i, rst_ni, vd_q, tod_q.second < 6'd60)
  `ASSERT_IMPL(a_wday_range, clk_i, rst_ni, vd_q, tod_q.weekday < 3'd7)
endmodule
`default_nettype wire

### hdl/e2c_date.sv
// ----------------------------------------------------------------------------
// e2c_date
// day count to year, day of year, month and day of month over three stages
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module e2c_date (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [e2c_pkg::DayBits-1:0] days_i,
  input  e2c_pkg::tod_t                tod_i,
  output logic                         vld_o,
  output e2c_pkg::tod_t                tod_o,
  output e2c_pkg::date_t               date_o
);
  // stage 1: four-year-cycle estimate floor((4*days+2)/1461), exact up to
  // 2100-02-28 and at most one low after that
  logic        v1_q, v2_q, v3_q;
  logic [7:0]  yo_d;
  logic [7:0]  yo1_q;
  logic [15:0] d1_q;
  e2c_pkg::tod_t t1_q, t2_q, t3_q;
  logic [17:0] yx;
  logic [37:0] yprod;
  assign yx    = {days_i, 2'b10};
  assign yprod = 38'(yx) * 38'd734937;
  assign yo_d  = yprod[37:30];

  // stage 2: days before the estimated year, correct up by one
  logic [7:0]  yo_n;
  logic [16:0] pre_cur, pre_next;
  logic [11:0] year_d;
  logic [8:0]  yday_d;
  logic [11:0] y2_q;
  logic [8:0]  yd2_q;

  // days in 1970..1970+yo-1: leap years every fourth year but 2100
  function automatic logic [16:0] days_before(input logic [7:0] yo);
    logic [8:0]  yo_p1;
    logic [16:0] r;
    yo_p1 = {1'b0, yo} + 9'd1;
    r = 17'(yo) * 17'd365 + 17'(yo_p1 >> 2)
      - ((yo >= 8'd131) ? 17'd1 : 17'd0);
    return r;
  endfunction

  always_comb begin
    yo_n     = yo1_q + 8'd1;
    pre_cur  = days_before(yo1_q);
    pre_next = days_before(yo_n);
    if ({1'b0, d1_q} >= pre_next) begin
      year_d = 12'd1970 + 12'(yo_n);
      yday_d = 9'({1'b0, d1_q} - pre_next);
    end else begin
      year_d = 12'd1970 + 12'(yo1_q);
      yday_d = 9'({1'b0, d1_q} - pre_cur);
    end
  end

  // stage 3: month search over cumulative table
  logic        leap;
  logic [3:0]  mon;
  logic [8:0]  mstart;
  logic [8:0]  cum;
  logic [8:0]  cum_tab [12];
  e2c_pkg::date_t date_q;

  always_comb begin
    leap = e2c_pkg::is_leap(y2_q);
    cum_tab[0]  = 9'd0;
    cum_tab[1]  = 9'd31;
    cum_tab[2]  = 9'd59;
    cum_tab[3]  = 9'd90;
    cum_tab[4]  = 9'd120;
    cum_tab[5]  = 9'd151;
    cum_tab[6]  = 9'd181;
    cum_tab[7]  = 9'd212;
    cum_tab[8]  = 9'd243;
    cum_tab[9]  = 9'd273;
    cum_tab[10] = 9'd304;
    cum_tab[11] = 9'd334;
    mon    = 4'd0;
    mstart = 9'd0;
    for (int m = 0; m < 12; m++) begin
      cum = cum_tab[m] + ((leap && m >= 2) ? 9'd1 : 9'd0);
      if (yd2_q >= cum) begin
        mon    = 4'(m);
        mstart = cum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      yo1_q  <= yo_d;
      d1_q   <= days_i;
      t1_q   <= tod_i;
      y2_q   <= year_d;
      yd2_q  <= yday_d;
      t2_q   <= t1_q;
      t3_q   <= t2_q;
      date_q <= '{year: y2_q, day_of_year: yd2_q, month: mon + 4'd1,
                  day_of_month: 5'(yd2_q - mstart) + 5'd1};
    end
  end

  assign vld_o  = v3_q;
  assign tod_o  = t3_q;
  assign date_o = date_q;

  `ASSERT_IMPL(a_yday_range, clk_i, rst_ni, v2_q, yd2_q < 9'd366)
  `ASSERT_IMPL(a_month_range, clk_i, rst_ni, v3_q, date_q.month >= 4'd1 && date_q.month <= 4'd12)
endmodule
`default_nettype wire

### hdl/epoch_to_calendar_converter.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_converter
// unix seconds to gregorian calendar breakdown
// ----------------------------------------------------------------------------
// Seven-stage pipeline: one transfer may enter every cycle while the output
// is not stalled; the stage count comes from giving each constant reciprocal
// multiply for day, time of day and year a stage of its own. A stall on the
// output freezes the whole pipeline, and input is taken whenever the output
// is empty or being taken.
`default_nettype none
module epoch_to_calendar_converter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [e2c_pkg::EpochBits-1:0] s_axis_tdata,   // epoch_seconds
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // second, minute, hour, weekday, year, day_of_year, month, day_of_month
  output logic [55:0]                    m_axis_tdata
);
  logic en;
  logic vs, vd;
  logic [e2c_pkg::DayBits-1:0] days;
  e2c_pkg::tod_t  tods, todd;
  e2c_pkg::date_t date;

  assign en            = m_axis_tready || !vd;
  assign s_axis_tready = en;

  e2c_split u_split (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(s_axis_tvalid),
    .secs_i(s_axis_tdata), .vld_o(vs), .days_o(days), .tod_o(tods)
  );

  e2c_date u_date (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en), .vld_i(vs), .days_i(days),
    .tod_i(tods), .vld_o(vd), .tod_o(todd), .date_o(date)
  );

  assign m_axis_tvalid = vd;
  assign m_axis_tdata  = {6'd0, date.day_of_month, date.month, date.day_of_year,
                          date.year, todd.weekday, todd.hour, todd.minute,
                          todd.second};
endmodule
`default_nettype wire

### tb/sv/epoch_to_calendar_converter_test.sv
// ----------------------------------------------------------------------------
// epoch_to_calendar_converter_test
// drives unix second counts through the converter and checks each calendar
// breakdown against a behavioural date calculation held in a scoreboard
// ----------------------------------------------------------------------------
`default_nettype none
module epoch_to_calendar_converter_test;

  typedef struct packed {
    logic [4:0]  day_of_month;
    logic [3:0]  month;
    logic [8:0]  day_of_year;
    logic [11:0] year;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } breakdown_t;

  class date_scoreboard;
    breakdown_t pending_dates[$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    function bit leap_year(int unsigned y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function breakdown_t to_calendar(logic [31:0] secs);
      breakdown_t b;
      int unsigned sod;
      int unsigned days;
      int unsigned yr;
      int unsigned mon;
      int unsigned mlen;
      int unsigned ylen;
      sod = secs % 86400;
      days = secs / 86400;
      b.second = 6'(sod % 60);
      b.minute = 6'((sod % 3600) / 60);
      b.hour = 5'(sod / 3600);
      b.weekday = 3'((days + 4) % 7);
      yr = 1970;
      ylen = leap_year(yr) ? 366 : 365;
      while (days >= ylen) begin
        days -= ylen;
        yr++;
        ylen = leap_year(yr) ? 366 : 365;
      end
      b.year = 12'(yr);
      b.day_of_year = 9'(days);
      mon = 0;
      while (mon < 11) begin
        case (mon)
          1: mlen = leap_year(yr) ? 29 : 28;
          3, 5, 8, 10: mlen = 30;
          default: mlen = 31;
        endcase
        if (days < mlen) break;
        days -= mlen;
        mon++;
      end
      b.month = 4'(mon + 1);
      b.day_of_month = 5'(days + 1);
      return b;
    endfunction

    function void note_epoch(logic [31:0] secs);
      pending_dates.push_back(to_calendar(secs));
    endfunction

    function void check_date(logic [55:0] got_bits);
      breakdown_t got;
      breakdown_t exp_b;
      got = got_bits[49:0];
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got_bits);
        errors++;
        return;
      end
      exp_b = pending_dates.pop_front();
      if (got.second != exp_b.second)
        $display("%0t: second exp %0d got %0d", $time, exp_b.second, got.second);
      if (got.minute != exp_b.minute)
        $display("%0t: minute exp %0d got %0d", $time, exp_b.minute, got.minute);
      if (got.hour != exp_b.hour)
        $display("%0t: hour exp %0d got %0d", $time, exp_b.hour, got.hour);
      if (got.weekday != exp_b.weekday)
        $display("%0t: weekday exp %0d got %0d", $time, exp_b.weekday, got.weekday);
      if (got.year != exp_b.year)
        $display("%0t: year exp %0d got %0d", $time, exp_b.year, got.year);
      if (got.day_of_year != exp_b.day_of_year)
        $display("%0t: day_of_year exp %0d got %0d", $time, exp_b.day_of_year,
                 got.day_of_year);
      if (got.month != exp_b.month)
        $display("%0t: month exp %0d got %0d", $time, exp_b.month, got.month);
      if (got.day_of_month != exp_b.day_of_month)
        $display("%0t: day_of_month exp %0d got %0d", $time, exp_b.day_of_month,
                 got.day_of_month);
      if (got != exp_b) errors++;
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // epoch_seconds
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // second, minute, hour, weekday, year, day_of_year, month, day_of_month
  logic [55:0] m_axis_tdata;

  date_scoreboard sb = new();
  int unsigned cycle_count = 0;
  bit quiet_phase = 1'b0;
  bit hold_sink = 1'b0;

  always #2 clk_i = ~clk_i;

  epoch_to_calendar_converter u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("epoch_to_calendar_converter verification failed");
      $finish;
    end
  end

  // result side: sample at the edge, then redraw ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_date(m_axis_tdata);
  end

  initial begin : sink_proc
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        m_axis_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_epoch(logic [31:0] secs);
    int unsigned gap;
    if (!quiet_phase && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= secs;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_epoch(secs);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_dates.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] random_epoch();
    logic [31:0] v;
    int unsigned k;
    k = $urandom_range(0, 3);
    v = $urandom();
    if (k == 1) v = $urandom_range(0, 200) * 86400 + $urandom_range(0, 2) * 86399;
    else if (k == 2) v = v & 32'h000f_ffff;
    return v;
  endfunction

  initial begin : drive_proc
    logic [31:0] directed[];
    // dates around leap days, year ends, the 2100 non-leap century
    directed = '{32'd0, 32'hffff_ffff, 32'd59, 32'd3599, 32'd86399,
      32'd86400, 32'd31535999, 32'd31536000, 32'd68169599, 32'd68169600,
      32'd951782399, 32'd951782400, 32'd951868800, 32'd946684799, 32'd946684800,
      32'd4107542399, 32'd4107542400, 32'd4102444799, 32'd4102444800,
      32'h8000_0000, 32'h7fff_ffff, 32'haaaa_aaaa, 32'h5555_5555, 32'd1709251199};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed[i]) send_epoch(directed[i]);
    drain_results();
    for (int i = 0; i < 300; i++) send_epoch(random_epoch());
    // starve the sink so the pipeline backs up against the sender
    hold_sink = 1'b1;
    fork
      for (int i = 0; i < 40; i++) send_epoch(random_epoch());
      begin
        repeat (60) @(posedge clk_i);
        hold_sink = 1'b0;
      end
    join
    drain_results();
    for (int i = 0; i < 300; i++) send_epoch(random_epoch());
    quiet_phase = 1'b1;
    for (int i = 0; i < 160; i++) send_epoch(random_epoch());
    drain_results();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending_dates.size() == 0)
      $display("epoch_to_calendar_converter verification clean");
    else
      $display("epoch_to_calendar_converter verification failed");
    $finish;
  end
endmodule
`default_nettype wire
